// ===== design/edm_pkg.sv =====
// edm_pkg: shared constants and types for the euclidean distance matrix block
// used by the controller, datapath and top level; no dependencies
`default_nettype none

package edm_pkg;

  localparam int MAX_NODES = 64;
  localparam int ADDR_W    = $clog2(MAX_NODES);
  localparam int IDX_W     = 6;
  localparam int COORD_W   = 16;
  localparam int CNT_W     = 7;
  localparam int DIST_W    = 18;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int SQ_W      = 2 * COORD_W;
  localparam int SUM_W     = SQ_W + 1;
  localparam int RAD_W     = SUM_W + 1;
  localparam int ROOT_W    = 17;
  localparam int WORD_W    = 2 * COORD_W;

  localparam logic [CNT_W-1:0]  COUNT_RESET = CNT_W'(64);
  localparam logic [CNT_W-1:0]  COUNT_MAX   = CNT_W'(MAX_NODES);
  localparam logic [DIST_W-1:0] DIST_DIAG   = '1;
  localparam logic [RAD_W-1:0]  ROOT_BIT0   = RAD_W'(64'h1_0000_0000);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_ROW  = 1'b1;

  typedef struct packed {
    logic load;
    logic row_start;
    logic row_latch;
    logic diff;
    logic mult;
    logic sum;
    logic root;
    logic emit;
    logic col_inc;
  } cmd_t;

  typedef struct packed {
    logic idx_ok;
    logic count_zero;
    logic root_last;
    logic col_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== design/edm_ram.sv =====
// edm_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module edm_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== design/edm_ctrl.sv =====
// edm_ctrl: sequencing state machine for loads and distance rows
// depends on edm_pkg for the command and status structs
`default_nettype none

module edm_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic          opcode_i,
  input  wire edm_pkg::sts_t sts_i,
  output edm_pkg::cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROW,
    S_READ,
    S_DIFF,
    S_MULT,
    S_SUM,
    S_ROOT,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept && sts_i.idx_ok) begin
          if (opcode_i == edm_pkg::OP_LOAD) begin
            cmd_o.load = 1'b1;
          end else if (!sts_i.count_zero) begin
            cmd_o.row_start = 1'b1;
            state_d         = S_ROW;
          end
        end
      end
      S_ROW: begin
        cmd_o.row_latch = 1'b1;
        state_d         = S_READ;
      end
      S_READ: begin
        state_d = S_DIFF;
      end
      S_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = S_MULT;
      end
      S_MULT: begin
        cmd_o.mult = 1'b1;
        state_d    = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_ROOT;
      end
      S_ROOT: begin
        cmd_o.root = 1'b1;
        if (sts_i.root_last) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.col_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.col_inc = 1'b1;
            state_d       = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/edm_datapath.sv =====
// edm_datapath: coordinate store, difference and square stages, bit-serial
// square root and output register; depends on edm_pkg and edm_ram
`default_nettype none

module edm_datapath (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire edm_pkg::cmd_t                        cmd_i,
  output edm_pkg::sts_t                             sts_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic        [edm_pkg::CNT_W-1:0]     cfg_data_i,
  input  wire logic        [edm_pkg::IDX_W-1:0]     node_index_i,
  input  wire logic signed [edm_pkg::COORD_W-1:0]   coord_x_i,
  input  wire logic signed [edm_pkg::COORD_W-1:0]   coord_y_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic             [edm_pkg::IDX_W-1:0]     column_index_o,
  output logic signed      [edm_pkg::DIST_W-1:0]    distance_o,
  output logic                                      last_in_row_o
);

  logic        [edm_pkg::CNT_W-1:0]   node_count_q;
  logic        [edm_pkg::CNT_W-1:0]   count_eff;
  logic        [edm_pkg::CNT_W-1:0]   count_q;
  logic        [edm_pkg::IDX_W-1:0]   row_idx_q;
  logic        [edm_pkg::IDX_W-1:0]   col_q;
  logic signed [edm_pkg::COORD_W-1:0] xi_q, yi_q;
  logic signed [edm_pkg::COORD_W-1:0] xj, yj;
  logic signed [edm_pkg::DIFF_W-1:0]  dx_q, dy_q;
  logic signed [2*edm_pkg::DIFF_W-1:0] sqx_full, sqy_full;
  logic        [edm_pkg::SQ_W-1:0]    sqx_q, sqy_q;
  logic        [edm_pkg::RAD_W-1:0]   rem_q, root_q, bit_q;
  logic        [edm_pkg::RAD_W-1:0]   trial;
  logic        [edm_pkg::WORD_W-1:0]  rdata;
  logic        [edm_pkg::ADDR_W-1:0]  raddr;
  logic                               out_valid_q;
  logic        [edm_pkg::IDX_W-1:0]   column_q;
  logic        [edm_pkg::DIST_W-1:0]  distance_q;
  logic                               last_q;

  assign count_eff = (node_count_q > edm_pkg::COUNT_MAX) ? edm_pkg::COUNT_MAX : node_count_q;

  assign sts_o.idx_ok     = (32'(node_index_i) < 32'(edm_pkg::MAX_NODES));
  assign sts_o.count_zero = (node_count_q == '0);
  assign sts_o.root_last  = bit_q[0];
  assign sts_o.col_last   = ((edm_pkg::CNT_W'(col_q) + edm_pkg::CNT_W'(1)) == count_q);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign raddr = cmd_i.row_start ? edm_pkg::ADDR_W'(node_index_i) : edm_pkg::ADDR_W'(col_q);

  edm_ram #(
    .Width(edm_pkg::WORD_W),
    .Depth(edm_pkg::MAX_NODES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.load),
    .waddr_i(edm_pkg::ADDR_W'(node_index_i)),
    .wdata_i({coord_x_i, coord_y_i}),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign xj       = rdata[edm_pkg::WORD_W-1:edm_pkg::COORD_W];
  assign yj       = rdata[edm_pkg::COORD_W-1:0];
  assign sqx_full = dx_q * dx_q;
  assign sqy_full = dy_q * dy_q;
  assign trial    = root_q + bit_q;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= edm_pkg::COUNT_RESET;
    end else if (cfg_we_i) begin
      node_count_q <= cfg_data_i;
    end
  end

  // row and column bookkeeping, arithmetic stages
  always_ff @(posedge clk_i) begin
    if (cmd_i.row_start) begin
      row_idx_q <= node_index_i;
      count_q   <= count_eff;
    end
    if (cmd_i.row_latch) begin
      xi_q  <= xj;
      yi_q  <= yj;
      col_q <= '0;
    end else if (cmd_i.col_inc) begin
      col_q <= col_q + edm_pkg::IDX_W'(1);
    end
    if (cmd_i.diff) begin
      dx_q <= edm_pkg::DIFF_W'(xi_q) - edm_pkg::DIFF_W'(xj);
      dy_q <= edm_pkg::DIFF_W'(yi_q) - edm_pkg::DIFF_W'(yj);
    end
    if (cmd_i.mult) begin
      sqx_q <= sqx_full[edm_pkg::SQ_W-1:0];
      sqy_q <= sqy_full[edm_pkg::SQ_W-1:0];
    end
    if (cmd_i.sum) begin
      rem_q  <= edm_pkg::RAD_W'(sqx_q) + edm_pkg::RAD_W'(sqy_q);
      root_q <= '0;
      bit_q  <= edm_pkg::ROOT_BIT0;
    end else if (cmd_i.root) begin
      if (rem_q >= trial) begin
        rem_q  <= rem_q - trial;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.emit) begin
      column_q   <= col_q;
      distance_q <= (col_q == row_idx_q) ? edm_pkg::DIST_DIAG
                                         : edm_pkg::DIST_W'(root_q[edm_pkg::ROOT_W-1:0]);
      last_q     <= sts_o.col_last;
    end
  end

  // output transfer flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign column_index_o = column_q;
  assign distance_o     = distance_q;
  assign last_in_row_o  = last_q;

endmodule

`default_nettype wire

// ===== design/euclidean_distance_matrix.sv =====
// load item: written to the store at the transfer edge
// row item: node_count columns, capped at 64; each column passes through read, difference, square,
// sum, bit-serial square root and emit steps
// results leave through an output register, so the next item can start while it waits
// rst_ni clears control state and sets node_count to 64; store contents stay undefined
`default_nettype none

module euclidean_distance_matrix (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic        [edm_pkg::CNT_W-1:0]    cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                opcode_i,
  input  wire logic        [edm_pkg::IDX_W-1:0]    node_index_i,
  input  wire logic signed [edm_pkg::COORD_W-1:0]  coord_x_i,
  input  wire logic signed [edm_pkg::COORD_W-1:0]  coord_y_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic             [edm_pkg::IDX_W-1:0]    column_index_o,
  output logic signed      [edm_pkg::DIST_W-1:0]   distance_o,
  output logic                                     last_in_row_o
);

  edm_pkg::cmd_t cmd;
  edm_pkg::sts_t sts;

  edm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .opcode_i  (opcode_i),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  edm_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .node_index_i  (node_index_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .column_index_o(column_index_o),
    .distance_o    (distance_o),
    .last_in_row_o (last_in_row_o)
  );

  // distance is either the diagonal marker or a root no larger than 92681
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (distance_o == edm_pkg::DIST_DIAG ||
                     (!distance_o[edm_pkg::DIST_W-1] && distance_o <= 18'sd92681)))
    else $error("distance out of range");

  // a row transfer with columns to emit makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && opcode_i == edm_pkg::OP_ROW &&
     sts.idx_ok && !sts.count_zero) |=> in_stall_o)
    else $error("row transfer did not start a row");

  // a load completes in the transfer cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && opcode_i == edm_pkg::OP_LOAD) |=> !in_stall_o)
    else $error("load left the block busy");

endmodule

`default_nettype wire
